// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define TRRL_ASSERT(label, clk_s, rstn_s, prop, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// A condition that must never be true at a rising edge outside reset.
`define TRRL_ASSERT_NEVER(label, clk_s, rstn_s, cond, msg) \
	`TRRL_ASSERT(label, clk_s, rstn_s, !(cond), msg)

`endif

// ===== rtl/core/trrl_pkg.sv =====
`default_nettype none

package trrl_pkg;

	localparam int TABLE_DEPTH  = 256;
	localparam int MAX_REPLICAS = 8;

	localparam int IDX_W     = $clog2(TABLE_DEPTH);
	localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
	localparam int REP_CNT_W = $clog2(MAX_REPLICAS + 1);

	localparam int ACTION_W        = 2;
	localparam int ENTRY_INDEX_W   = 8;
	localparam int TOKEN_W         = 64;
	localparam int ENDPOINT_W      = 32;
	localparam int HASH_W          = 64;
	localparam int RANK_W          = 3;
	localparam int REPLICA_COUNT_W = 4;
	localparam int TOKEN_COUNT_W   = 9;
	localparam int CFG_DATA_W      = 9;
	localparam int CFG_INDEX_W     = 1;

	typedef logic [ACTION_W-1:0] action_t;
	localparam action_t ACT_LOAD  = 2'd0;
	localparam action_t ACT_WRITE = 2'd1;
	localparam action_t ACT_READ  = 2'd2;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	localparam cfg_index_t CFG_REPLICA_COUNT = 1'd0;
	localparam cfg_index_t CFG_TOKEN_COUNT   = 1'd1;

	typedef struct packed {
		logic load;
		logic start;
		logic probe;
		logic narrow;
		logic fetch;
		logic advance;
	} trrl_cmd_t;

	typedef struct packed {
		logic searching;
		logic last;
	} trrl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/trrl_req_if.sv =====
`default_nettype none

interface trrl_req_if
	import trrl_pkg::*;
();
	logic                     valid;
	logic                     ready;
	action_t                  action;
	logic [ENTRY_INDEX_W-1:0] entry_index;
	logic [TOKEN_W-1:0]       token_value;
	logic [ENDPOINT_W-1:0]    endpoint_value;
	logic [HASH_W-1:0]        key_hash;

	modport source (
		output valid, action, entry_index, token_value, endpoint_value, key_hash,
		input  ready
	);

	modport sink (
		input  valid, action, entry_index, token_value, endpoint_value, key_hash,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/trrl_rsp_if.sv =====
`default_nettype none

interface trrl_rsp_if
	import trrl_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [ENDPOINT_W-1:0] endpoint;
	logic [RANK_W-1:0]     replica_rank;
	logic                  last;

	modport source (
		output valid, endpoint, replica_rank, last,
		input  ready
	);

	modport sink (
		input  valid, endpoint, replica_rank, last,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/trrl_datapath.sv =====
`default_nettype none

module trrl_datapath
	import trrl_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire trrl_cmd_t                cmd,
	output trrl_sts_t                     sts,
	input  wire logic                     cfg_we,
	input  wire cfg_index_t               cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_wdata,
	input  wire action_t                  action,
	input  wire logic [ENTRY_INDEX_W-1:0] entry_index,
	input  wire logic [TOKEN_W-1:0]       token_value,
	input  wire logic [ENDPOINT_W-1:0]    endpoint_value,
	input  wire logic [HASH_W-1:0]        key_hash,
	output logic [ENDPOINT_W-1:0]         endpoint,
	output logic [RANK_W-1:0]             replica_rank
);

	logic [TOKEN_W-1:0]    token_mem_q [TABLE_DEPTH];
	logic [ENDPOINT_W-1:0] endpoint_mem_q [TABLE_DEPTH];

	logic [REPLICA_COUNT_W-1:0] replica_count_q;
	logic [TOKEN_COUNT_W-1:0]   token_count_q;

	logic [HASH_W-1:0]     hash_q;
	logic                  is_read_q;
	logic [CNT_W-1:0]      lo_q;
	logic [CNT_W-1:0]      hi_q;
	logic [CNT_W-1:0]      mid_q;
	logic [CNT_W-1:0]      n_q;
	logic [REP_CNT_W-1:0]  reps_q;
	logic [REP_CNT_W-1:0]  rank_q;
	logic [IDX_W-1:0]      at_q;
	logic [TOKEN_W-1:0]    token_rd_q;
	logic [ENDPOINT_W-1:0] endpoint_rd_q;

	logic [CNT_W-1:0]     n_sat;
	logic [REP_CNT_W-1:0] reps_sat;
	logic [CNT_W-1:0]     mid;
	logic [IDX_W-1:0]     pos;
	logic [IDX_W-1:0]     at_next;
	logic [IDX_W-1:0]     load_idx;
	logic                 load_in_range;
	logic                 searching;
	logic                 token_rd_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replica_count_q <= REPLICA_COUNT_W'(1);
			token_count_q   <= TOKEN_COUNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REPLICA_COUNT: replica_count_q <= cfg_wdata[REPLICA_COUNT_W-1:0];
				CFG_TOKEN_COUNT:   token_count_q   <= cfg_wdata[TOKEN_COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (token_count_q == '0) begin
			n_sat = CNT_W'(1);
		end else if (32'(token_count_q) > 32'(TABLE_DEPTH)) begin
			n_sat = CNT_W'(TABLE_DEPTH);
		end else begin
			n_sat = CNT_W'(token_count_q);
		end
		if (replica_count_q == '0) begin
			reps_sat = REP_CNT_W'(1);
		end else if (32'(replica_count_q) > 32'(MAX_REPLICAS)) begin
			reps_sat = REP_CNT_W'(MAX_REPLICAS);
		end else begin
			reps_sat = REP_CNT_W'(replica_count_q);
		end
	end

	assign searching     = lo_q < hi_q;
	assign mid           = lo_q + ((hi_q - lo_q) >> 1);
	assign pos           = (lo_q >= n_q) ? '0 : lo_q[IDX_W-1:0];
	assign at_next       = (CNT_W'(at_q) + CNT_W'(1) == n_q) ? '0 : at_q + IDX_W'(1);
	assign load_idx      = IDX_W'(entry_index);
	assign load_in_range = 32'(entry_index) < 32'(TABLE_DEPTH);
	assign token_rd_en   = cmd.probe && searching;

	always_ff @(posedge clk) begin
		if (cmd.load && load_in_range) begin
			token_mem_q[load_idx] <= token_value;
		end
		if (token_rd_en) begin
			token_rd_q <= token_mem_q[mid[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && load_in_range) begin
			endpoint_mem_q[load_idx] <= endpoint_value;
		end
		if (cmd.fetch) begin
			endpoint_rd_q <= endpoint_mem_q[at_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hash_q    <= key_hash;
			is_read_q <= action == ACT_READ;
			lo_q      <= '0;
			hi_q      <= n_sat;
			n_q       <= n_sat;
			reps_q    <= reps_sat;
		end
		if (cmd.probe) begin
			if (searching) begin
				mid_q <= mid;
			end else begin
				at_q   <= pos;
				rank_q <= '0;
			end
		end
		if (cmd.narrow) begin
			if (token_rd_q < hash_q) begin
				lo_q <= mid_q + CNT_W'(1);
			end else begin
				hi_q <= mid_q;
			end
		end
		if (cmd.advance) begin
			rank_q <= rank_q + REP_CNT_W'(1);
			at_q   <= at_next;
		end
	end

	assign sts.searching = searching;
	assign sts.last      = is_read_q || (rank_q + REP_CNT_W'(1) == reps_q);
	assign endpoint      = endpoint_rd_q;
	assign replica_rank  = RANK_W'(rank_q);

endmodule

`default_nettype wire

// ===== rtl/core/trrl_controller.sv =====
`default_nettype none

module trrl_controller
	import trrl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire action_t   in_action,
	input  wire logic      out_ready,
	input  wire trrl_sts_t sts,
	output trrl_cmd_t      cmd,
	output logic           in_ready,
	output logic           out_valid
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROBE,
		S_NARROW,
		S_FETCH,
		S_SEND
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   out_valid_q;
	logic   in_fire;
	logic   is_lookup;

	assign in_fire   = (state_q == S_IDLE) && ready_q && in_valid;
	assign is_lookup = (in_action == ACT_WRITE) || (in_action == ACT_READ);

	always_comb begin
		cmd.load    = in_fire && (in_action == ACT_LOAD);
		cmd.start   = in_fire && is_lookup;
		cmd.probe   = state_q == S_PROBE;
		cmd.narrow  = state_q == S_NARROW;
		cmd.fetch   = state_q == S_FETCH;
		cmd.advance = (state_q == S_SEND) && out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ready_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire && is_lookup) begin
						ready_q <= 1'b0;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					state_q <= sts.searching ? S_NARROW : S_FETCH;
				end
				S_NARROW: begin
					state_q <= S_PROBE;
				end
				S_FETCH: begin
					out_valid_q <= 1'b1;
					state_q     <= S_SEND;
				end
				S_SEND: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (sts.last) begin
							ready_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_FETCH;
						end
					end
				end
				default: begin
					state_q     <= S_IDLE;
					ready_q     <= 1'b1;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_ready  = ready_q;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/token_ring_replica_lookup.sv =====
// Channel   Dir  Beat contents
// req       in   action, entry_index, token_value, endpoint_value, key_hash
// rsp       out  endpoint, replica_rank, last
// cfg_*     in   replica_count (index 0), token_count (index 1), no read-back
//
// A load beat is written in the cycle it is taken and the block stays ready.
// A lookup runs at most ceil(log2(n+1)) search steps over n valid tokens and
// then sends R result beats; every search step reads the token table and every
// result reads the endpoint table, each through its own registered read port.
// Reset leaves the tables unwritten and sets replica_count and token_count to 1.
// A stalled result beat holds the block; no new beat is taken until the last
// result of the lookup has been delivered.
`default_nettype none

`include "assert_macros.svh"

module token_ring_replica_lookup
	import trrl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	trrl_req_if.sink                   req,
	trrl_rsp_if.source                 rsp,
	input  wire logic                  cfg_we,
	input  wire cfg_index_t            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	trrl_cmd_t cmd;
	trrl_sts_t sts;

	trrl_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_action (req.action),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (req.ready),
		.out_valid (rsp.valid)
	);

	trrl_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.action         (req.action),
		.entry_index    (req.entry_index),
		.token_value    (req.token_value),
		.endpoint_value (req.endpoint_value),
		.key_hash       (req.key_hash),
		.endpoint       (rsp.endpoint),
		.replica_rank   (rsp.replica_rank)
	);

	assign rsp.last = sts.last;

	`TRRL_ASSERT_NEVER(a_no_overlap, clk, arst_n, req.ready && rsp.valid, "request taken while a result is pending")
	`TRRL_ASSERT(a_lookup_busy, clk, arst_n, req.valid && req.ready && (req.action == ACT_WRITE || req.action == ACT_READ) |=> !req.ready, "lookup did not block the request side")
	`TRRL_ASSERT(a_last_frees, clk, arst_n, rsp.valid && rsp.ready && rsp.last |=> req.ready && !rsp.valid, "block not ready after the final result")
	`TRRL_ASSERT(a_next_fetch, clk, arst_n, rsp.valid && rsp.ready && !rsp.last |=> !rsp.valid && !req.ready, "result beat not followed by a table read")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import trrl_pkg::*;

	localparam action_t ACT_NONE = 2'd3;
	localparam int TOTAL_ITEMS = 470;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		action_t                  action;
		logic [ENTRY_INDEX_W-1:0] entry_index;
		logic [TOKEN_W-1:0]       token_value;
		logic [ENDPOINT_W-1:0]    endpoint_value;
		logic [HASH_W-1:0]        key_hash;
	} ring_beat_t;

	typedef struct packed {
		logic [ENDPOINT_W-1:0] endpoint;
		logic [RANK_W-1:0]     rank;
		logic                  last;
	} replica_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	trrl_req_if req ();
	trrl_rsp_if rsp ();

	token_ring_replica_lookup u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	logic [TOKEN_W-1:0]         ring_token [TABLE_DEPTH];
	logic [ENDPOINT_W-1:0]      ring_endpoint [TABLE_DEPTH];
	logic [REPLICA_COUNT_W-1:0] replica_setting;
	logic [TOKEN_COUNT_W-1:0]   token_setting;
	replica_t                   expected_replicas [$];

	ring_beat_t         pending_beats [$];
	logic [TOKEN_W-1:0] plan_token [TABLE_DEPTH];
	int unsigned        items_planned = 0;
	int unsigned        fail_count = 0;
	int unsigned        cycles = 0;

	ring_beat_t  beat_on_bus;
	int unsigned burst_left;
	int unsigned gap_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic predict_replicas(input ring_beat_t b);
		int unsigned n, lo, hi, mid, reps, i;
		replica_t r;
		case (b.action)
			ACT_LOAD: begin
				ring_token[b.entry_index] = b.token_value;
				ring_endpoint[b.entry_index] = b.endpoint_value;
			end
			ACT_WRITE, ACT_READ: begin
				n = (token_setting == '0) ? 1 :
					(32'(token_setting) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(token_setting);
				lo = 0;
				hi = n;
				while (lo < hi) begin
					mid = lo + (hi - lo) / 2;
					if (ring_token[mid] < b.key_hash) lo = mid + 1;
					else hi = mid;
				end
				if (lo >= n) lo = 0;
				if (b.action == ACT_READ) reps = 1;
				else reps = (replica_setting == '0) ? 1 :
					(32'(replica_setting) > MAX_REPLICAS) ? MAX_REPLICAS :
					32'(replica_setting);
				for (i = 0; i < reps; i++) begin
					r.endpoint = ring_endpoint[(lo + i) % n];
					r.rank = i[RANK_W-1:0];
					r.last = (i + 1 == reps);
					expected_replicas.push_back(r);
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (req.valid && req.ready)
				predict_replicas(beat_on_bus);
			if (!req.valid || req.ready) begin
				if (gap_left > 0 || pending_beats.size() == 0) begin
					if (gap_left > 0) gap_left--;
					req.valid <= 1'b0;
				end else begin
					beat_on_bus = pending_beats.pop_front();
					req.valid <= 1'b1;
					req.action <= beat_on_bus.action;
					req.entry_index <= beat_on_bus.entry_index;
					req.token_value <= beat_on_bus.token_value;
					req.endpoint_value <= beat_on_bus.endpoint_value;
					req.key_hash <= beat_on_bus.key_hash;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 15);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
					end
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_replica();
		replica_t want;
		if (expected_replicas.size() == 0) begin
			$display("%0t: unexpected beat endpoint %h rank %0d last %0d", $time,
				rsp.endpoint, rsp.replica_rank, rsp.last);
			fail_count++;
		end else begin
			want = expected_replicas.pop_front();
			check_field("endpoint", want.endpoint, rsp.endpoint);
			check_field("replica_rank", 32'(want.rank), 32'(rsp.replica_rank));
			check_field("last", 32'(want.last), 32'(rsp.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready)
				check_replica();
			case (cycles[9:8])
				2'd0: rsp.ready <= 1'b1;
				2'd1: rsp.ready <= ($urandom_range(0, 1) != 0);
				2'd2: rsp.ready <= ($urandom_range(0, 5) == 0);
				default: rsp.ready <= (cycles[3:0] >= 4'd10);
			endcase
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic plan_load(input int unsigned idx, input logic [TOKEN_W-1:0] tok,
			input logic [ENDPOINT_W-1:0] ep);
		ring_beat_t b;
		b = '0;
		b.action = ACT_LOAD;
		b.entry_index = idx[ENTRY_INDEX_W-1:0];
		b.token_value = tok;
		b.endpoint_value = ep;
		b.key_hash = rand64();
		pending_beats.push_back(b);
		plan_token[idx] = tok;
		items_planned++;
	endtask

	task automatic plan_lookup(input action_t act, input logic [HASH_W-1:0] hash);
		ring_beat_t b;
		b.action = act;
		b.entry_index = ENTRY_INDEX_W'($urandom);
		b.token_value = rand64();
		b.endpoint_value = $urandom;
		b.key_hash = hash;
		pending_beats.push_back(b);
		items_planned++;
	endtask

	task automatic plan_ignored();
		ring_beat_t b;
		b.action = ACT_NONE;
		b.entry_index = ENTRY_INDEX_W'($urandom);
		b.token_value = rand64();
		b.endpoint_value = $urandom;
		b.key_hash = rand64();
		pending_beats.push_back(b);
	endtask

	// Rising tokens with occasional duplicates, loaded upward or downward.
	task automatic plan_sorted_ring(input int unsigned n);
		logic [TOKEN_W-1:0] toks [TABLE_DEPTH];
		logic [TOKEN_W-1:0] acc;
		int unsigned shift, i, idx;
		bit down;
		shift = $clog2(n + 1);
		acc = rand64() >> (shift + 2);
		for (i = 0; i < n; i++) begin
			toks[i] = acc;
			if ($urandom_range(0, 7) != 0) acc = acc + (rand64() >> shift);
		end
		down = ($urandom_range(0, 1) != 0);
		for (i = 0; i < n; i++) begin
			idx = down ? n - 1 - i : i;
			plan_load(idx, toks[idx], $urandom);
		end
	endtask

	function automatic logic [HASH_W-1:0] pick_hash(input int unsigned n);
		logic [TOKEN_W-1:0] near;
		near = plan_token[$urandom_range(0, n - 1)];
		case ($urandom_range(0, 6))
			0: return '0;
			1: return '1;
			2: return near;
			3: return near + 1;
			4: return near - 1;
			default: return rand64();
		endcase
	endfunction

	task automatic settle();
		do @(negedge clk);
		while (pending_beats.size() != 0 || req.valid || expected_replicas.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_REPLICA_COUNT) replica_setting = value[REPLICA_COUNT_W-1:0];
		else token_setting = value[TOKEN_COUNT_W-1:0];
	endtask

	initial begin
		logic [TOKEN_W-1:0] seed_tok [8];
		logic [ENDPOINT_W-1:0] seed_ep [8];
		int unsigned tc, n, lookups, k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_REPLICA_COUNT;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.action = ACT_LOAD;
		req.entry_index = '0;
		req.token_value = '0;
		req.endpoint_value = '0;
		req.key_hash = '0;
		rsp.ready = 1'b0;
		replica_setting = REPLICA_COUNT_W'(1);
		token_setting = TOKEN_COUNT_W'(1);
		seed_tok = '{64'h0, 64'h1, 64'h0000_0000_FFFF_FFFF, 64'h5555_5555_5555_5555,
			64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA,
			64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF};
		seed_ep = '{32'h0, 32'h1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000,
			32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		plan_load(0, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
		plan_lookup(ACT_READ, '0);
		plan_lookup(ACT_WRITE, '1);
		plan_lookup(ACT_WRITE, 64'h8000_0000_0000_0000);
		plan_ignored();
		settle();

		write_reg(CFG_REPLICA_COUNT, CFG_DATA_W'(0));
		write_reg(CFG_TOKEN_COUNT, CFG_DATA_W'(0));
		plan_lookup(ACT_WRITE, 64'h8000_0000_0000_0001);
		plan_lookup(ACT_READ, 64'd5);
		settle();

		write_reg(CFG_REPLICA_COUNT, CFG_DATA_W'(15));
		plan_lookup(ACT_WRITE, '0);
		for (k = 0; k < 8; k++)
			plan_load(k, seed_tok[k], seed_ep[k]);
		plan_load(TABLE_DEPTH - 1, rand64(), $urandom);
		settle();

		write_reg(CFG_TOKEN_COUNT, CFG_DATA_W'(8));
		write_reg(CFG_REPLICA_COUNT, CFG_DATA_W'(8));
		plan_lookup(ACT_WRITE, '0);
		plan_lookup(ACT_WRITE, 64'h5555_5555_5555_5555);
		plan_lookup(ACT_WRITE, 64'h5555_5555_5555_5556);
		plan_lookup(ACT_READ, '1);
		plan_lookup(ACT_WRITE, 64'h9000_0000_0000_0000);
		plan_lookup(ACT_READ, 64'd2);
		settle();

		write_reg(CFG_TOKEN_COUNT, CFG_DATA_W'(3));
		write_reg(CFG_REPLICA_COUNT, CFG_DATA_W'(5));
		plan_lookup(ACT_WRITE, 64'h0000_0001_0000_0000);
		plan_lookup(ACT_READ, 64'd1);
		settle();

		write_reg(CFG_TOKEN_COUNT, CFG_DATA_W'(TABLE_DEPTH));
		write_reg(CFG_REPLICA_COUNT, CFG_DATA_W'($urandom_range(1, 8)));
		plan_sorted_ring(TABLE_DEPTH);
		for (k = 0; k < 25; k++)
			plan_lookup(($urandom_range(0, 2) == 0) ? ACT_READ : ACT_WRITE,
				pick_hash(TABLE_DEPTH));
		settle();

		while (items_planned < TOTAL_ITEMS) begin
			case ($urandom_range(0, 7))
				0: tc = $urandom_range(TABLE_DEPTH, 511);
				1: tc = 0;
				default: tc = $urandom_range(1, 16);
			endcase
			n = (tc == 0) ? 1 : (tc > TABLE_DEPTH) ? TABLE_DEPTH : tc;
			write_reg(CFG_TOKEN_COUNT, CFG_DATA_W'(tc));
			write_reg(CFG_REPLICA_COUNT, CFG_DATA_W'($urandom_range(0, 15)));
			if (n < TABLE_DEPTH && $urandom_range(0, 9) < 7)
				plan_sorted_ring(n);
			else
				repeat ($urandom_range(0, 4))
					plan_load($urandom_range(0, TABLE_DEPTH - 1), rand64(), $urandom);
			lookups = $urandom_range(4, 12);
			for (k = 0; k < lookups; k++) begin
				if ($urandom_range(0, 15) == 0) plan_ignored();
				plan_lookup(($urandom_range(0, 2) == 0) ? ACT_READ : ACT_WRITE, pick_hash(n));
			end
			settle();
		end

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
